### sv/crte_pkg.sv
`default_nettype none

package crte_pkg;

    localparam int CMD_W   = 3;
    localparam int KIND_W  = 2;
    localparam int ODO_W   = 32;
    localparam int CNT_W   = 16;
    localparam int LIMIT_W = 6;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_ENQUEUE   = 3'd1,
        CMD_REPLY     = 3'd2,
        CMD_WR_DONE   = 3'd3,
        CMD_WR_ERROR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_QFULL   = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_WR_ERR  = 2'd3
    } t_status;

    typedef enum logic {
        EV_SEND   = 1'b0,
        EV_FINISH = 1'b1
    } t_event;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_RESEND  = 2'd1,
        REG_LIMIT   = 2'd2
    } t_reg_idx;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

    localparam logic [CNT_W-1:0]   TIMEOUT_RST = 16'd50;
    localparam logic [CNT_W-1:0]   RESEND_RST  = 16'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 6'd32;

endpackage

`default_nettype wire

### sv/crte_if.sv
`default_nettype none

interface crte_req_if #(
    parameter int TAG_WIDTH = 8
);
    import crte_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [KIND_W-1:0]    cmd_kind;
    logic [TAG_WIDTH-1:0] tag;
    logic                 reply_ok;
    logic [ODO_W-1:0]     reply_dx;
    logic [ODO_W-1:0]     reply_dy;
    logic [ODO_W-1:0]     reply_dtheta;

    modport source (
        output valid, cmd, cmd_kind, tag, reply_ok, reply_dx, reply_dy, reply_dtheta,
        input  ready
    );
    modport sink (
        input  valid, cmd, cmd_kind, tag, reply_ok, reply_dx, reply_dy, reply_dtheta,
        output ready
    );
endinterface

interface crte_res_if #(
    parameter int TAG_WIDTH = 8
);
    import crte_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 event_type;
    logic [TAG_WIDTH-1:0] out_tag;
    logic [KIND_W-1:0]    out_kind;
    logic                 success;
    logic [1:0]           status_code;
    logic [CNT_W-1:0]     attempts_made;
    logic [ODO_W-1:0]     out_dx;
    logic [ODO_W-1:0]     out_dy;
    logic [ODO_W-1:0]     out_dtheta;

    modport source (
        output valid, event_type, out_tag, out_kind, success, status_code,
               attempts_made, out_dx, out_dy, out_dtheta,
        input  ready
    );
    modport sink (
        input  valid, event_type, out_tag, out_kind, success, status_code,
               attempts_made, out_dx, out_dy, out_dtheta,
        output ready
    );
endinterface

`default_nettype wire

### sv/command_retry_timeout_engine.sv
// Path: an event transfer lands in the input register, is decoded from there and its result,
// if any, is caught in the result register once that register is free (two register stages).
// Throughput: one event per cycle; only a result left untaken by the sink holds the input.
// Reset (i_rst_n low, synchronous): queue empty, no active command, timeout 50,
// resend 20, queue limit 32. The pending-command memory is not cleared.
`default_nettype none

module command_retry_timeout_engine #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TAG_WIDTH   = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    crte_req_if.sink                           i_req,
    crte_res_if.source                         o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crte_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [crte_pkg::DATA_W-1:0]   pwdata,
    output logic      [crte_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import crte_pkg::*;

    // queue geometry
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW = TAG_WIDTH + KIND_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // active command context
    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [TAG_WIDTH-1:0] tag;
        logic                 sent;
        logic                 ack_wait;
        logic                 busy;
        logic [CNT_W-1:0]     att;
        logic [CNT_W-1:0]     since_start;
        logic [CNT_W-1:0]     since_send;
    } t_active;

    typedef struct packed {
        logic                 event_type;
        logic [TAG_WIDTH-1:0] tag;
        logic [KIND_W-1:0]    kind;
        logic                 success;
        logic [1:0]           status;
        logic [CNT_W-1:0]     attempts;
        logic [ODO_W-1:0]     dx;
        logic [ODO_W-1:0]     dy;
        logic [ODO_W-1:0]     dtheta;
    } t_result;

    // ---------------------------------------------------------------------------------------
    // Configuration registers (APB, zero wait state)
    // ---------------------------------------------------------------------------------------
    logic [CNT_W-1:0]   r_timeout;
    logic [CNT_W-1:0]   r_resend;
    logic [LIMIT_W-1:0] r_limit;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_resend  <= RESEND_RST;
            r_limit   <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TIMEOUT: r_timeout <= pwdata[CNT_W-1:0];
                REG_RESEND:  r_resend  <= pwdata[CNT_W-1:0];
                REG_LIMIT:   r_limit   <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TIMEOUT: prdata = DATA_W'(r_timeout);
            REG_RESEND:  prdata = DATA_W'(r_resend);
            REG_LIMIT:   prdata = DATA_W'(r_limit);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // Input register: one event waits here until the result register can take its result
    // ---------------------------------------------------------------------------------------
    logic                 r_s1_valid;
    logic [CMD_W-1:0]     r_s1_cmd;
    logic [KIND_W-1:0]    r_s1_kind;
    logic [TAG_WIDTH-1:0] r_s1_tag;
    logic                 r_s1_ok;
    logic [ODO_W-1:0]     r_s1_dx;
    logic [ODO_W-1:0]     r_s1_dy;
    logic [ODO_W-1:0]     r_s1_dth;
    logic                 r_out_valid;
    t_result              r_res;
    logic                 out_free;
    logic                 s1_fire;

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_cmd  <= i_req.cmd;
            r_s1_kind <= i_req.cmd_kind;
            r_s1_tag  <= i_req.tag;
            r_s1_ok   <= i_req.reply_ok;
            r_s1_dx   <= i_req.reply_dx;
            r_s1_dy   <= i_req.reply_dy;
            r_s1_dth  <= i_req.reply_dtheta;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Pending-command queue. r_head_data always holds the entry at the head pointer: the
    // memory is read at the next head address, with the write data bypassed when an entry
    // lands in an empty queue.
    // ---------------------------------------------------------------------------------------
    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_head_data;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic [EW-1:0] w_entry;

    assign w_entry = {r_s1_tag, r_s1_kind};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= w_entry;
        end
        if (w_push && (r_tail == n_head)) begin
            r_head_data <= w_entry;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    // ---------------------------------------------------------------------------------------
    // Event handling
    // ---------------------------------------------------------------------------------------
    t_active r_act;
    t_active n_act;
    t_active fresh;
    t_result res;
    logic    res_v;
    logic    q_full;

    // context of the head entry, as loaded when it becomes active
    always_comb begin
        fresh             = '0;
        fresh.valid       = 1'b1;
        fresh.kind        = r_head_data[KIND_W-1:0];
        fresh.tag         = r_head_data[EW-1:KIND_W];
    end

    assign q_full = (LW'(r_count) >= LW'(QUEUE_DEPTH)) || (LW'(r_count) >= LW'(r_limit));

    always_comb begin
        n_act   = r_act;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        w_push  = 1'b0;
        res_v   = 1'b0;
        res     = '0;

        if (s1_fire) begin
            case (t_cmd'(r_s1_cmd))
                CMD_TICK: begin
                    // idle: pull the oldest pending command (only one pop per event is
                    // possible, the timeout pull below needs an already active command)
                    if (!r_act.valid && (r_count != '0)) begin
                        n_act   = fresh;
                        n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                    if (n_act.valid) begin
                        if (n_act.sent) begin
                            if (n_act.since_start != CNT_MAX) begin
                                n_act.since_start = n_act.since_start + 1'b1;
                            end
                            if (n_act.since_send != CNT_MAX) begin
                                n_act.since_send = n_act.since_send + 1'b1;
                            end
                        end
                        if (n_act.sent && (n_act.since_start >= r_timeout)) begin
                            res_v          = 1'b1;
                            res.event_type = EV_FINISH;
                            res.tag        = n_act.tag;
                            res.kind       = n_act.kind;
                            res.status     = ST_TIMEOUT;
                            res.attempts   = n_act.att;
                            n_act.valid    = 1'b0;
                            n_act.sent     = 1'b0;
                            n_act.ack_wait = 1'b0;
                            n_act.busy     = 1'b0;
                            if (r_count != '0) begin
                                n_act   = fresh;
                                n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end else if (!n_act.busy &&
                                     (!n_act.ack_wait || (n_act.since_send >= r_resend))) begin
                            if (!n_act.sent) begin
                                n_act.sent        = 1'b1;
                                n_act.since_start = '0;
                            end
                            n_act.since_send = '0;
                            n_act.busy       = 1'b1;
                            n_act.ack_wait   = 1'b0;
                            if (n_act.att != CNT_MAX) begin
                                n_act.att = n_act.att + 1'b1;
                            end
                            res_v          = 1'b1;
                            res.event_type = EV_SEND;
                            res.tag        = n_act.tag;
                            res.kind       = n_act.kind;
                            res.attempts   = n_act.att;
                        end
                    end
                end
                CMD_ENQUEUE: begin
                    if (q_full) begin
                        res_v          = 1'b1;
                        res.event_type = EV_FINISH;
                        res.tag        = r_s1_tag;
                        res.kind       = r_s1_kind;
                        res.status     = ST_QFULL;
                    end else begin
                        w_push  = 1'b1;
                        n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_REPLY: begin
                    if (r_act.valid && (r_s1_kind == r_act.kind) && r_s1_ok) begin
                        res_v          = 1'b1;
                        res.event_type = EV_FINISH;
                        res.tag        = r_act.tag;
                        res.kind       = r_act.kind;
                        res.success    = 1'b1;
                        res.status     = ST_OK;
                        res.attempts   = r_act.att;
                        if (r_act.kind == KIND_REQUEST) begin
                            res.dx     = r_s1_dx;
                            res.dy     = r_s1_dy;
                            res.dtheta = r_s1_dth;
                        end
                        n_act.valid    = 1'b0;
                        n_act.sent     = 1'b0;
                        n_act.ack_wait = 1'b0;
                        n_act.busy     = 1'b0;
                    end
                end
                CMD_WR_DONE: begin
                    if (r_act.valid && r_act.busy) begin
                        n_act.busy     = 1'b0;
                        n_act.ack_wait = 1'b1;
                    end
                end
                CMD_WR_ERROR: begin
                    if (r_act.valid && r_act.busy) begin
                        res_v          = 1'b1;
                        res.event_type = EV_FINISH;
                        res.tag        = r_act.tag;
                        res.kind       = r_act.kind;
                        res.status     = ST_WR_ERR;
                        res.attempts   = r_act.att;
                        n_act.valid    = 1'b0;
                        n_act.sent     = 1'b0;
                        n_act.ack_wait = 1'b0;
                        n_act.busy     = 1'b0;
                        if (r_count != '0) begin
                            n_act   = fresh;
                            n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_act   <= n_act;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_v) begin
            r_res <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.event_type    = r_res.event_type;
    assign o_res.out_tag       = r_res.tag;
    assign o_res.out_kind      = r_res.kind;
    assign o_res.success       = r_res.success;
    assign o_res.status_code   = r_res.status;
    assign o_res.attempts_made = r_res.attempts;
    assign o_res.out_dx        = r_res.dx;
    assign o_res.out_dy        = r_res.dy;
    assign o_res.out_dtheta    = r_res.dtheta;

    // ---------------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_busy_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act.busy |-> (r_act.valid && r_act.sent))
        else $error("write busy without a sent active command");

    a_ack_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act.ack_wait |-> (r_act.valid && r_act.sent && !r_act.busy))
        else $error("awaiting ack in an inconsistent context");

    a_send_attempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && res_v && (res.event_type == EV_SEND)) |=> (r_act.busy && r_act.att != '0))
        else $error("send transfer without busy write and counted attempt");

endmodule

`default_nettype wire

### verif/command_retry_timeout_engine_tb.sv
`timescale 1ns / 100ps

import crte_pkg::*;

localparam int QUEUE_SLOTS = 32;
localparam int TAG_W       = 8;

localparam logic [KIND_W-1:0] KIND_DISTANCE = 2'd0;
localparam logic [KIND_W-1:0] KIND_TURN     = 2'd1;
localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              ok;
    logic [ODO_W-1:0]  dx;
    logic [ODO_W-1:0]  dy;
    logic [ODO_W-1:0]  dth;
} engine_event_t;

typedef struct packed {
    t_event            ev;
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic              success;
    t_status           status;
    logic [CNT_W-1:0]  attempts;
    logic [ODO_W-1:0]  dx;
    logic [ODO_W-1:0]  dy;
    logic [ODO_W-1:0]  dth;
} engine_result_t;

// Shadow of the stop-and-wait engine plus the results it still owes.
class arq_scoreboard;
    logic [CNT_W-1:0]   timeout_lim;
    logic [CNT_W-1:0]   resend_gap;
    logic [LIMIT_W-1:0] depth_cap;

    logic [KIND_W-1:0]  held_kind [QUEUE_SLOTS];
    logic [TAG_W-1:0]   held_tag  [QUEUE_SLOTS];
    int unsigned        rd_ptr;
    int unsigned        wr_ptr;
    int unsigned        held;

    bit                 live;
    bit                 launched;
    bit                 ack_wait;
    bit                 wr_busy;
    logic [KIND_W-1:0]  cur_kind;
    logic [TAG_W-1:0]   cur_tag;
    logic [CNT_W-1:0]   sends;
    logic [CNT_W-1:0]   age_first;
    logic [CNT_W-1:0]   age_last;

    engine_result_t     awaited [$];

    function new();
        timeout_lim = TIMEOUT_RST;
        resend_gap  = RESEND_RST;
        depth_cap   = LIMIT_RST;
        rd_ptr      = 0;
        wr_ptr      = 0;
        held        = 0;
        live        = 1'b0;
        launched    = 1'b0;
        ack_wait    = 1'b0;
        wr_busy     = 1'b0;
        cur_kind    = '0;
        cur_tag     = '0;
        sends       = '0;
        age_first   = '0;
        age_last    = '0;
    endfunction

    function void apply_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        case (idx)
            REG_TIMEOUT: timeout_lim = val[CNT_W-1:0];
            REG_RESEND:  resend_gap  = val[CNT_W-1:0];
            REG_LIMIT:   depth_cap   = val[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function void push_result(t_event ev, logic [TAG_W-1:0] tag, logic [KIND_W-1:0] kind,
                              logic ok, t_status st, logic [CNT_W-1:0] attempts,
                              logic [ODO_W-1:0] dx, logic [ODO_W-1:0] dy,
                              logic [ODO_W-1:0] dth);
        engine_result_t r;
        r.ev       = ev;
        r.tag      = tag;
        r.kind     = kind;
        r.success  = ok;
        r.status   = st;
        r.attempts = attempts;
        r.dx       = dx;
        r.dy       = dy;
        r.dth      = dth;
        awaited.insert(awaited.size(), r);
    endfunction

    function void pull_next();
        if (held == 0) return;
        cur_kind  = held_kind[rd_ptr];
        cur_tag   = held_tag[rd_ptr];
        rd_ptr    = (rd_ptr + 1) % QUEUE_SLOTS;
        held--;
        live      = 1'b1;
        launched  = 1'b0;
        ack_wait  = 1'b0;
        wr_busy   = 1'b0;
        sends     = '0;
        age_first = '0;
        age_last  = '0;
    endfunction

    function void finish_active(logic ok, t_status st, logic [ODO_W-1:0] dx,
                                logic [ODO_W-1:0] dy, logic [ODO_W-1:0] dth);
        push_result(EV_FINISH, cur_tag, cur_kind, ok, st, sends, dx, dy, dth);
        live     = 1'b0;
        launched = 1'b0;
        ack_wait = 1'b0;
        wr_busy  = 1'b0;
    endfunction

    function bit run_tick();
        if (!live) pull_next();
        if (!live) return 1'b0;
        if (launched) begin
            if (age_first != CNT_SAT) age_first = age_first + 1'b1;
            if (age_last != CNT_SAT) age_last = age_last + 1'b1;
            if (age_first >= timeout_lim) begin
                finish_active(1'b0, ST_TIMEOUT, '0, '0, '0);
                pull_next();
                return 1'b1;
            end
        end
        if (wr_busy) return 1'b1;
        if (!ack_wait || age_last >= resend_gap) begin
            if (!launched) begin
                launched  = 1'b1;
                age_first = '0;
            end
            age_last = '0;
            wr_busy  = 1'b1;
            ack_wait = 1'b0;
            if (sends != CNT_SAT) sends = sends + 1'b1;
            push_result(EV_SEND, cur_tag, cur_kind, 1'b0, ST_OK, sends, '0, '0, '0);
        end
        return 1'b1;
    endfunction

    // Returns 1 when the event had any effect on the engine.
    function bit absorb_event(engine_event_t ev);
        int unsigned cap;
        case (ev.cmd)
            CMD_TICK: return run_tick();
            CMD_ENQUEUE: begin
                cap = (depth_cap > QUEUE_SLOTS) ? QUEUE_SLOTS : depth_cap;
                if (held >= cap) begin
                    push_result(EV_FINISH, ev.tag, ev.kind, 1'b0, ST_QFULL, '0, '0, '0, '0);
                end else begin
                    held_kind[wr_ptr] = ev.kind;
                    held_tag[wr_ptr]  = ev.tag;
                    wr_ptr = (wr_ptr + 1) % QUEUE_SLOTS;
                    held++;
                end
                return 1'b1;
            end
            CMD_REPLY: begin
                if (!live || ev.kind != cur_kind || !ev.ok) return 1'b0;
                if (cur_kind == KIND_REQUEST)
                    finish_active(1'b1, ST_OK, ev.dx, ev.dy, ev.dth);
                else
                    finish_active(1'b1, ST_OK, '0, '0, '0);
                return 1'b1;
            end
            CMD_WR_DONE: begin
                if (!(live && wr_busy)) return 1'b0;
                wr_busy  = 1'b0;
                ack_wait = 1'b1;
                return 1'b1;
            end
            CMD_WR_ERROR: begin
                if (!(live && wr_busy)) return 1'b0;
                finish_active(1'b0, ST_WR_ERR, '0, '0, '0);
                pull_next();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Empty string when the result matches the oldest one owed.
    function string check_result(engine_result_t got);
        engine_result_t want;
        string diffs;
        if (awaited.size() == 0)
            return $sformatf("unexpected result: type %0d tag %0d kind %0d status %0d",
                             got.ev, got.tag, got.kind, got.status);
        want  = awaited[0];
        awaited.delete(0);
        diffs = "";
        if (got.ev !== want.ev)
            diffs = {diffs, $sformatf(" type %0d/%0d", got.ev, want.ev)};
        if (got.tag !== want.tag)
            diffs = {diffs, $sformatf(" tag %0d/%0d", got.tag, want.tag)};
        if (got.kind !== want.kind)
            diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
        if (got.success !== want.success)
            diffs = {diffs, $sformatf(" success %0d/%0d", got.success, want.success)};
        if (got.status !== want.status)
            diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
        if (got.attempts !== want.attempts)
            diffs = {diffs, $sformatf(" attempts %0d/%0d", got.attempts, want.attempts)};
        if (got.dx !== want.dx)
            diffs = {diffs, $sformatf(" dx %h/%h", got.dx, want.dx)};
        if (got.dy !== want.dy)
            diffs = {diffs, $sformatf(" dy %h/%h", got.dy, want.dy)};
        if (got.dth !== want.dth)
            diffs = {diffs, $sformatf(" dtheta %h/%h", got.dth, want.dth)};
        if (diffs != "") return {"result got/want:", diffs};
        return "";
    endfunction
endclass

module command_retry_timeout_engine_tb;

    // Cycles with no transfer on either channel before the run is abandoned.
    // Worst honest stretch is a random send gap plus a random result stall
    // plus the pipeline path and three register writes, so this is ample.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline depth is two stages; allow a margin before touching registers.
    localparam int SETTLE_CYCLES  = 6;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    crte_req_if #(.TAG_WIDTH(TAG_W)) req_if ();
    crte_res_if #(.TAG_WIDTH(TAG_W)) res_if ();

    command_retry_timeout_engine #(
        .QUEUE_DEPTH (QUEUE_SLOTS),
        .TAG_WIDTH   (TAG_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    arq_scoreboard board;
    int            mismatches   = 0;
    int            quiet_cycles = 0;
    // When set, both sides run without any random idle cycles.
    bit            no_gaps      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Random odometry half the time, else the Q16.16 extremes, zero or all ones.
    function automatic logic [ODO_W-1:0] draw_odometry();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic engine_event_t ev_of(logic [CMD_W-1:0] c, logic [KIND_W-1:0] k,
                                            logic [TAG_W-1:0] t, logic ok,
                                            logic [ODO_W-1:0] dx, logic [ODO_W-1:0] dy,
                                            logic [ODO_W-1:0] dth);
        engine_event_t ev;
        ev.cmd  = c;
        ev.kind = k;
        ev.tag  = t;
        ev.ok   = ok;
        ev.dx   = dx;
        ev.dy   = dy;
        ev.dth  = dth;
        return ev;
    endfunction

    // Random event, steered by the shadow state so that most traffic forms
    // proper command lifecycles: enqueue, send, write done, replies matching
    // the active kind. The rest is mismatched replies, stray write reports and
    // unused codes.
    function automatic engine_event_t make_event();
        engine_event_t ev;
        int            roll;
        ev.cmd  = CMD_TICK;
        ev.kind = KIND_W'($urandom_range(0, 3));
        ev.tag  = TAG_W'($urandom);
        ev.ok   = 1'($urandom);
        ev.dx   = draw_odometry();
        ev.dy   = draw_odometry();
        ev.dth  = draw_odometry();
        roll    = $urandom_range(0, 99);
        if (roll < 42) begin
            ev.cmd = CMD_TICK;
        end else if (roll < 56) begin
            ev.cmd  = CMD_ENQUEUE;
            ev.kind = ($urandom_range(0, 9) == 0) ? KIND_SPARE
                                                  : KIND_W'($urandom_range(0, 2));
        end else if (roll < 73) begin
            ev.cmd = CMD_REPLY;
            if (board.live && $urandom_range(0, 4) != 0) ev.kind = board.cur_kind;
            ev.ok = ($urandom_range(0, 6) != 0);
        end else if (roll < 90) begin
            ev.cmd = CMD_WR_DONE;
        end else if (roll < 94) begin
            ev.cmd = CMD_WR_ERROR;
        end else begin
            ev.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with valid still high so a zero gap gives back-to-back transfers.
    task automatic send_item(input engine_event_t ev);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.cmd          <= ev.cmd;
        req_if.cmd_kind     <= ev.kind;
        req_if.tag          <= ev.tag;
        req_if.reply_ok     <= ev.ok;
        req_if.reply_dx     <= ev.dx;
        req_if.reply_dy     <= ev.dy;
        req_if.reply_dtheta <= ev.dth;
        req_if.valid        <= 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        void'(board.absorb_event(ev));
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed result has been taken.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (board.awaited.size() != 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup, access, then idle, so writes never overlap.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.apply_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // One configuration, then quota random events, ignored ones included.
    task automatic run_phase(input logic [CNT_W-1:0] to, input logic [CNT_W-1:0] rs,
                             input logic [LIMIT_W-1:0] lim, input int quota);
        int done_items;
        settle();
        write_reg(REG_TIMEOUT, DATA_W'(to));
        write_reg(REG_RESEND, DATA_W'(rs));
        write_reg(REG_LIMIT, DATA_W'(lim));
        done_items = 0;
        while (done_items < quota) begin
            if (done_items % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0) drain_results();
            send_item(make_event());
            done_items++;
        end
    endtask

    // Result side: random stall per result, check at the transfer edge.
    initial begin : result_sink
        int             stall;
        engine_result_t got;
        string          msg;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.ev       = t_event'(res_if.event_type);
            got.tag      = res_if.out_tag;
            got.kind     = res_if.out_kind;
            got.success  = res_if.success;
            got.status   = t_status'(res_if.status_code);
            got.attempts = res_if.attempts_made;
            got.dx       = res_if.out_dx;
            got.dy       = res_if.out_dy;
            got.dth      = res_if.out_dtheta;
            msg = board.check_result(got);
            if (msg != "") report_mismatch(msg);
            @(negedge i_clk);
        end
    end

    // Watchdog: a long stretch with no transfer on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("command_retry_timeout_engine_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        engine_event_t script [$];

        board               = new();
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_TICK;
        req_if.cmd_kind     = '0;
        req_if.tag          = '0;
        req_if.reply_ok     = 1'b0;
        req_if.reply_dx     = '0;
        req_if.reply_dy     = '0;
        req_if.reply_dtheta = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset configuration.
        // Stray events on an idle engine: all ignored.
        script.insert(script.size(), ev_of(CMD_TICK, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_REQUEST, 8'h00, 1'b1, '1, '1, '1));
        script.insert(script.size(), ev_of(CMD_WR_DONE, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_WR_ERROR, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_UNUSED_HI, KIND_SPARE, 8'hFF, 1'b1, '1, '1, '1));
        // Four commands queued, including the spare kind code.
        script.insert(script.size(), ev_of(CMD_ENQUEUE, KIND_REQUEST, 8'hFF, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_ENQUEUE, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_ENQUEUE, KIND_SPARE, 8'hA5, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_ENQUEUE, KIND_TURN, 8'h5A, 1'b0, '0, '0, '0));
        // Reply before a tick: nothing active yet.
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_REQUEST, 8'h00, 1'b1, '0, '0, '0));
        // Request goes active and is sent; second tick finds the write busy.
        script.insert(script.size(), ev_of(CMD_TICK, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_TICK, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_WR_DONE, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        // Wrong kind, then an error reply: both leave it waiting.
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_TURN, 8'h00, 1'b1, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_REQUEST, 8'h00, 1'b0, '0, '0, '0));
        // Ok reply carrying extreme odometry.
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_REQUEST, 8'h00, 1'b1,
                                           32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // Distance command sent, then lost to a write error; spare kind takes over.
        script.insert(script.size(), ev_of(CMD_TICK, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_WR_ERROR, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        // Ok reply before any send of the spare-kind command.
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_SPARE, 8'h00, 1'b1, '1, '1, '1));
        // Turn command: send, write done, ok reply without odometry.
        script.insert(script.size(), ev_of(CMD_TICK, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_WR_DONE, KIND_DISTANCE, 8'h00, 1'b0, '0, '0, '0));
        script.insert(script.size(), ev_of(CMD_REPLY, KIND_TURN, 8'h00, 1'b1, '1, '1, '1));
        foreach (script[k]) send_item(script[k]);

        // Random phases across register settings, extremes included:
        // zero timeout and resend, widest timeout and resend, queue limit of
        // zero, one and above the store depth.
        run_phase(16'd8, 16'd3, 6'd4, 100);
        run_phase(16'd0, 16'd0, 6'd63, 80);
        run_phase(16'hFFFF, 16'hFFFF, 6'd1, 80);
        run_phase(16'd1, 16'd1, 6'd32, 80);
        run_phase(16'd20, 16'd5, 6'd0, 40);
        run_phase(CNT_W'($urandom_range(2, 40)), CNT_W'($urandom_range(0, 12)),
                  LIMIT_W'($urandom_range(1, 40)), 90);
        run_phase(CNT_W'($urandom_range(2, 40)), CNT_W'($urandom_range(0, 12)),
                  LIMIT_W'($urandom_range(1, 40)), 90);
        run_phase(16'hFFFF, 16'd0, 6'd63, 70);

        // Everything owed must have arrived; then let the pipeline run dry.
        settle();
        if (board.awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", board.awaited.size()));

        if (mismatches == 0) begin
            $display("command_retry_timeout_engine_tb OK");
        end else begin
            $display("command_retry_timeout_engine_tb NOT OK");
        end
        $finish;
    end

endmodule

### command_retry_timeout_engine.f
sv/crte_pkg.sv
sv/crte_if.sv
sv/command_retry_timeout_engine.sv
verif/command_retry_timeout_engine_tb.sv
